>>> hw/rtl/distance_vector_route_update_defines.svh
// Assertion macros for the RTL of the route update block, used by dvru_dp.
// DVRU_ASSERT checks a property; DVRU_NEVER checks that a condition never holds.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define DVRU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dvru: property check failed");
`define DVRU_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dvru: forbidden condition seen");
`else
`define DVRU_ASSERT(lbl, clk, rst_n, prop)
`define DVRU_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/dvru_pkg.sv
`timescale 1ns / 1ps
package dvru_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W        = 32;
    localparam int DIST_W        = 8;
    localparam int ACT_W         = 3;
    localparam int OUT_IDX_W     = 6;

    localparam logic [DIST_W-1:0] MAX_DIST = 8'hFF;

    // tdata widths, padded to whole bytes
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 56;

    typedef enum logic [ACT_W-1:0] {
        ACT_REFRESH = 3'd0,
        ACT_BETTER  = 3'd1,
        ACT_KEPT    = 3'd2,
        ACT_INSERT  = 3'd3,
        ACT_FULL    = 3'd4
    } t_action;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [DIST_W-1:0] cost;
        logic [ADDR_W-1:0] hop;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic scan;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/dvru_ram.sv
`timescale 1ns / 1ps
module dvru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/dvru_ctrl.sv
`timescale 1ns / 1ps
module dvru_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output dvru_pkg::t_dp_cmd  o_cmd,
    input  dvru_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.capture  = 1'b0;
        o_cmd.scan     = 1'b0;
        o_cmd.load_out = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/dvru_dp.sv
`timescale 1ns / 1ps
`include "distance_vector_route_update_defines.svh"
module dvru_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dvru_pkg::t_dp_cmd                   i_cmd,
    output dvru_pkg::t_dp_stat                  o_stat,
    input  logic [dvru_pkg::ADDR_W-1:0]         i_dest_network,
    input  logic [dvru_pkg::DIST_W-1:0]         i_advertised_distance,
    input  logic [dvru_pkg::ADDR_W-1:0]         i_sender_address,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dvru_pkg::ACT_W-1:0]          o_action,
    output logic [dvru_pkg::OUT_IDX_W-1:0]      o_entry_index,
    output logic [dvru_pkg::DIST_W-1:0]         o_route_distance,
    output logic [dvru_pkg::ADDR_W-1:0]         o_route_next_hop
);

    // captured request
    logic [dvru_pkg::ADDR_W-1:0]    r_dest;
    logic [dvru_pkg::DIST_W-1:0]    r_dist;
    logic [dvru_pkg::ADDR_W-1:0]    r_sender;

    // scan state
    logic [dvru_pkg::CNT_W-1:0]     r_addr;
    logic [dvru_pkg::IDX_W-1:0]     r_cmp_addr;
    logic                           r_pend;
    logic [dvru_pkg::CNT_W-1:0]     r_used;

    // resolved result, then output register
    dvru_pkg::t_action              r_res_act;
    logic [dvru_pkg::OUT_IDX_W-1:0] r_res_idx;
    logic [dvru_pkg::DIST_W-1:0]    r_res_dist;
    logic [dvru_pkg::ADDR_W-1:0]    r_res_hop;
    logic                           r_out_valid;
    dvru_pkg::t_action              r_out_act;
    logic [dvru_pkg::OUT_IDX_W-1:0] r_out_idx;
    logic [dvru_pkg::DIST_W-1:0]    r_out_dist;
    logic [dvru_pkg::ADDR_W-1:0]    r_out_hop;

    dvru_pkg::t_entry               rd_entry;
    dvru_pkg::t_entry               wr_entry;
    logic [dvru_pkg::IDX_W-1:0]     wr_addr;
    logic                           we;
    logic                           re;
    logic                           hit;
    logic                           more;
    logic                           full;
    logic                           done;
    logic                           ins;
    dvru_pkg::t_action              res_act;
    logic [dvru_pkg::OUT_IDX_W-1:0] res_idx;
    logic [dvru_pkg::DIST_W-1:0]    res_dist;
    logic [dvru_pkg::ADDR_W-1:0]    res_hop;

    dvru_ram #(
        .WIDTH ($bits(dvru_pkg::t_entry)),
        .DEPTH (dvru_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (re),
        .i_raddr (r_addr[dvru_pkg::IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // slots fill in order and are never freed: valid entries are 0 .. r_used-1
    assign hit  = r_pend && (rd_entry.dest == r_dest);
    assign more = r_addr < r_used;
    assign full = r_used == dvru_pkg::CNT_W'(dvru_pkg::TABLE_ENTRIES);
    assign done = i_cmd.scan && (hit || !more);
    assign re   = i_cmd.scan && !hit && more;
    assign ins  = done && !hit && !full;

    always_comb begin
        we            = 1'b0;
        wr_addr       = r_cmp_addr;
        wr_entry.dest = r_dest;
        wr_entry.cost = r_dist;
        wr_entry.hop  = r_sender;
        res_act       = dvru_pkg::ACT_FULL;
        res_idx       = '0;
        res_dist      = '0;
        res_hop       = '0;
        if (hit) begin
            res_idx = dvru_pkg::OUT_IDX_W'(r_cmp_addr);
            if (rd_entry.hop == r_sender) begin
                we           = done;
                wr_entry.hop = rd_entry.hop;
                res_act      = dvru_pkg::ACT_REFRESH;
                res_dist     = r_dist;
                res_hop      = rd_entry.hop;
            end else if (r_dist < rd_entry.cost) begin
                we       = done;
                res_act  = dvru_pkg::ACT_BETTER;
                res_dist = r_dist;
                res_hop  = r_sender;
            end else begin
                res_act  = dvru_pkg::ACT_KEPT;
                res_dist = rd_entry.cost;
                res_hop  = rd_entry.hop;
            end
        end else if (!full) begin
            we       = ins;
            wr_addr  = r_used[dvru_pkg::IDX_W-1:0];
            res_act  = dvru_pkg::ACT_INSERT;
            res_idx  = dvru_pkg::OUT_IDX_W'(r_used);
            res_dist = r_dist;
            res_hop  = r_sender;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dest   <= i_dest_network;
            r_sender <= i_sender_address;
            // one hop further, saturating
            r_dist   <= (i_advertised_distance == dvru_pkg::MAX_DIST) ?
                        dvru_pkg::MAX_DIST : i_advertised_distance + 1'b1;
        end
        if (re) begin
            r_cmp_addr <= r_addr[dvru_pkg::IDX_W-1:0];
        end
        if (done) begin
            r_res_act  <= res_act;
            r_res_idx  <= res_idx;
            r_res_dist <= res_dist;
            r_res_hop  <= res_hop;
        end
        if (i_cmd.load_out) begin
            r_out_act  <= r_res_act;
            r_out_idx  <= r_res_idx;
            r_out_dist <= r_res_dist;
            r_out_hop  <= r_res_hop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_addr <= '0;
                r_pend <= 1'b0;
            end else if (re) begin
                r_addr <= r_addr + 1'b1;
                r_pend <= 1'b1;
            end else if (i_cmd.scan) begin
                r_pend <= 1'b0;
            end
            if (ins) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.scan_done = done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out_act;
    assign o_entry_index    = r_out_idx;
    assign o_route_distance = r_out_dist;
    assign o_route_next_hop = r_out_hop;

    `DVRU_NEVER(a_used_in_range, i_clk, i_rst_n, r_used > dvru_pkg::CNT_W'(dvru_pkg::TABLE_ENTRIES))
    `DVRU_NEVER(a_addr_le_used, i_clk, i_rst_n, r_addr > r_used)
    `DVRU_ASSERT(a_write_in_scan, i_clk, i_rst_n, we |-> (i_cmd.scan && done))
    `DVRU_ASSERT(a_insert_counts, i_clk, i_rst_n, ins |=> (r_used == $past(r_used) + 1'b1))
    `DVRU_ASSERT(a_load_when_free, i_clk, i_rst_n, i_cmd.load_out |-> (!r_out_valid || i_out_ready))

endmodule

>>> hw/rtl/distance_vector_route_update.sv
`timescale 1ns / 1ps
// Each advertisement scans the route table from slot 0 until a hit (a hit in slot i
//   scans i + 1 slots) or until the fill count (a miss scans every filled slot).
// One item at a time: the single read port of the route table RAM reads one slot a cycle;
//   a new advertisement is taken only after the previous result is in the output register.
// Reset (synchronous, active low) clears the controller, the fill count and the
//   output valid; table contents are not cleared, slots at or above the fill count are never read.
module distance_vector_route_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // route advertisement in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] dest_network, [39:32] advertised_distance, [71:40] sender_address
    input  logic [dvru_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // update result out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] action, [8:3] entry_index, [16:9] route_distance,
    // [48:17] route_next_hop, [55:49] zero
    output logic [dvru_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    dvru_pkg::t_dp_cmd              cmd;
    dvru_pkg::t_dp_stat             stat;
    logic [dvru_pkg::ACT_W-1:0]     action;
    logic [dvru_pkg::OUT_IDX_W-1:0] entry_index;
    logic [dvru_pkg::DIST_W-1:0]    route_distance;
    logic [dvru_pkg::ADDR_W-1:0]    route_next_hop;

    // Controller: idle -> scan (one table slot per cycle) -> hand result to output reg.
    dvru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Datapath: captured request, table RAM, compare/update, result registers.
    // A new advertisement can be taken while the previous result still waits.
    dvru_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_dest_network        (s_axis_tdata[31:0]),
        .i_advertised_distance (s_axis_tdata[39:32]),
        .i_sender_address      (s_axis_tdata[71:40]),
        .o_out_valid           (m_axis_tvalid),
        .i_out_ready           (m_axis_tready),
        .o_action              (action),
        .o_entry_index         (entry_index),
        .o_route_distance      (route_distance),
        .o_route_next_hop      (route_next_hop)
    );

    // pack result fields, lowest field first, zero fill to byte boundary
    assign m_axis_tdata = {7'b0, route_next_hop, route_distance, entry_index, action};

endmodule
